/* hw/rtl/dspwm_pkg.sv */
// Shared types and constants for the dual servo PWM generator.
// Used by dspwm_lane, dspwm_timer and dual_servo_pwm_generator_core.
// No dependencies.
package dspwm_pkg;

    // Default counter width and fixed field widths
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int PULSE_W         = 16;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int OP_W            = 3;

    // Command codes
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_ENABLE   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_BOTH = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_PAN  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_TILT = 3'd4;
    localparam logic [OP_W-1:0] OP_DISABLE  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_DIV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_PULSE = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0]   DIV_RST    = 17'd72;
    localparam int                 PERIOD_RST = 20000;
    localparam logic [PULSE_W-1:0] MIN_RST    = 16'd500;
    localparam logic [PULSE_W-1:0] MAX_RST    = 16'd2500;
    localparam logic [PULSE_W-1:0] CENTER_RST = 16'd1500;
    localparam logic [CFG_W-1:0]   DIV_MAX    = 17'd65536;

    // Input transaction
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PULSE_W-1:0] pan_pulse;
        logic [PULSE_W-1:0] tilt_pulse;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic pan_out;
        logic tilt_out;
        logic accepted;
        logic running;
    } t_out_item;

    // Per-channel compare control
    typedef struct packed {
        logic               load;       // enable: load active and preload
        logic               set_pre;    // set command: write preload
        logic               wrap;       // counter wrap: preload -> active
        logic               center_we;  // centre write while stopped
        logic [PULSE_W-1:0] center;
    } t_lane_ctrl;

endpackage

/* hw/rtl/dual_servo_pwm_generator_core.sv */
// Top level of the two-channel servo PWM generator: command decode,
// configuration registers, output register. Depends on dspwm_pkg,
// dspwm_timer and dspwm_lane.
//
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       from block o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// One transaction per cycle unless the input stalls; its result appears in
// the output register on the next cycle. The whole state update (prescaler,
// frame counter, both compare lanes) completes in the accepting cycle.
// Reset is synchronous; no clearing pass is needed.
// The input stalls only while the output register is full and stalled.
module dual_servo_pwm_generator_core
    import dspwm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Longest frame the counter allows
    localparam int PMAX_I = (COUNT_WIDTH >= PULSE_W) ? (1 << PULSE_W) : (1 << COUNT_WIDTH);
    localparam logic [CFG_W-1:0] PERIOD_MAX = CFG_W'(PMAX_I);
    localparam logic [CFG_W-1:0] PERIOD_RST_C =
        CFG_W'((PERIOD_RST > PMAX_I) ? PMAX_I : PERIOD_RST);

    logic               r_init;
    logic [CFG_W-1:0]   r_div;
    logic [CFG_W-1:0]   r_period;
    logic [PULSE_W-1:0] r_min;
    logic [PULSE_W-1:0] r_max;
    logic               r_running, n_running;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_acc;
    logic               can_set;
    logic               pan_ok, tilt_ok;
    logic               en_ok;
    logic               acc;
    logic               is_tick, is_enable, set_pan, set_tilt;
    logic               wrap;
    logic               pan_lvl, tilt_lvl;
    logic [PULSE_W-1:0] frame_next;
    t_lane_ctrl         pan_ctrl, tilt_ctrl;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign can_set    = r_init && r_running;
    assign en_ok      = r_init && pan_ok && tilt_ok;

    // Command decode
    always_comb begin
        is_tick   = 1'b0;
        is_enable = 1'b0;
        set_pan   = 1'b0;
        set_tilt  = 1'b0;
        acc       = 1'b0;
        n_running = r_running;
        unique case (i_in_data.op)
            OP_TICK: begin
                is_tick = 1'b1;
                acc     = 1'b1;
            end
            OP_ENABLE: begin
                is_enable = en_ok;
                acc       = en_ok;
                n_running = en_ok;
            end
            OP_SET_BOTH: begin
                set_pan  = can_set && pan_ok && tilt_ok;
                set_tilt = can_set && pan_ok && tilt_ok;
                acc      = can_set && pan_ok && tilt_ok;
            end
            OP_SET_PAN: begin
                set_pan = can_set && pan_ok;
                acc     = can_set && pan_ok;
            end
            OP_SET_TILT: begin
                set_tilt = can_set && tilt_ok;
                acc      = can_set && tilt_ok;
            end
            OP_DISABLE: begin
                n_running = 1'b0;
                acc       = 1'b1;
            end
            default: begin
            end
        endcase
        if (!in_acc) begin
            n_running = r_running;
        end
    end

    // Configuration registers; divider and period clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= 1'b1;
            r_div    <= DIV_RST;
            r_period <= PERIOD_RST_C;
            r_min    <= MIN_RST;
            r_max    <= MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INIT_DONE:    r_init <= i_cfg_data[0];
                CFG_PRESCALE_DIV: begin
                    if (i_cfg_data == '0) begin
                        r_div <= CFG_W'(1);
                    end else if (i_cfg_data > DIV_MAX) begin
                        r_div <= DIV_MAX;
                    end else begin
                        r_div <= i_cfg_data;
                    end
                end
                CFG_PERIOD_TICKS: begin
                    if (i_cfg_data < CFG_W'(2)) begin
                        r_period <= CFG_W'(2);
                    end else if (i_cfg_data > PERIOD_MAX) begin
                        r_period <= PERIOD_MAX;
                    end else begin
                        r_period <= i_cfg_data;
                    end
                end
                CFG_MIN_PULSE:    r_min <= i_cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE:    r_max <= i_cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Shared counter
    dspwm_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_acc && is_tick && r_running),
        .i_restart    (in_acc && is_enable),
        .i_div        (r_div),
        .i_period     (r_period),
        .o_frame_next (frame_next),
        .o_wrap       (wrap)
    );

    // Lane controls
    always_comb begin
        pan_ctrl.load      = in_acc && is_enable;
        pan_ctrl.set_pre   = in_acc && set_pan;
        pan_ctrl.wrap      = wrap;
        pan_ctrl.center_we = i_cfg_we && (i_cfg_index == CFG_CENTER_PULSE) && !r_running;
        pan_ctrl.center    = i_cfg_data[PULSE_W-1:0];
        tilt_ctrl          = pan_ctrl;
        tilt_ctrl.set_pre  = in_acc && set_tilt;
    end

    dspwm_lane u_pan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (pan_ctrl),
        .i_pulse      (i_in_data.pan_pulse),
        .i_min        (r_min),
        .i_max        (r_max),
        .i_run_next   (n_running),
        .i_frame_next (frame_next),
        .o_pulse_ok   (pan_ok),
        .o_level      (pan_lvl)
    );

    dspwm_lane u_tilt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tilt_ctrl),
        .i_pulse      (i_in_data.tilt_pulse),
        .i_min        (r_min),
        .i_max        (r_max),
        .i_run_next   (n_running),
        .i_frame_next (frame_next),
        .o_pulse_ok   (tilt_ok),
        .o_level      (tilt_lvl)
    );

    // Running flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_running <= n_running;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.pan_out  <= pan_lvl;
            r_out.tilt_out <= tilt_lvl;
            r_out.accepted <= acc;
            r_out.running  <= n_running;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.running) |-> (!o_out_data.pan_out && !o_out_data.tilt_out))
        else $error("PWM output high while stopped");

    a_tick_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_TICK) |=> (o_out_valid && o_out_data.accepted))
        else $error("tick not accepted");

    a_disable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_DISABLE) |=> (!r_running && !o_out_data.running))
        else $error("disable did not stop the block");

    a_run_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.running == r_running))
        else $error("reported running flag differs from state");

endmodule

/* hw/rtl/dspwm_lane.sv */
// One PWM channel: preload and active compares, range check, pin level.
// Depends on dspwm_pkg.
module dspwm_lane
    import dspwm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctrl         i_ctrl,
    input  logic [PULSE_W-1:0] i_pulse,
    input  logic [PULSE_W-1:0] i_min,
    input  logic [PULSE_W-1:0] i_max,
    input  logic               i_run_next,
    input  logic [PULSE_W-1:0] i_frame_next,
    output logic               o_pulse_ok,
    output logic               o_level
);

    logic [PULSE_W-1:0] r_active, n_active;
    logic [PULSE_W-1:0] r_preload, n_preload;

    // Range check: empty when min exceeds max
    assign o_pulse_ok = (i_pulse >= i_min) && (i_pulse <= i_max);

    // Next compare values
    always_comb begin
        n_active  = r_active;
        n_preload = r_preload;
        if (i_ctrl.load) begin
            n_active  = i_pulse;
            n_preload = i_pulse;
        end else if (i_ctrl.center_we) begin
            n_active  = i_ctrl.center;
            n_preload = i_ctrl.center;
        end else begin
            if (i_ctrl.wrap) begin
                n_active = r_preload;
            end
            if (i_ctrl.set_pre) begin
                n_preload = i_pulse;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= CENTER_RST;
            r_preload <= CENTER_RST;
        end else begin
            r_active  <= n_active;
            r_preload <= n_preload;
        end
    end

    // PWM1: high while counter below compare
    assign o_level = i_run_next && (i_frame_next < n_active);

endmodule

/* hw/rtl/dspwm_timer.sv */
// Shared prescaler and frame counter for both channels.
// Depends on dspwm_pkg.
module dspwm_timer
    import dspwm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_restart,
    input  logic [CFG_W-1:0]   i_div,
    input  logic [CFG_W-1:0]   i_period,
    output logic [PULSE_W-1:0] o_frame_next,
    output logic               o_wrap
);

    // Frame count never reaches 65536
    localparam int FW = (COUNT_WIDTH < PULSE_W) ? COUNT_WIDTH : PULSE_W;

    logic [PULSE_W-1:0] r_pre, n_pre;
    logic [FW-1:0]      r_frame, n_frame;
    logic               pre_last;
    logic               frame_last;

    assign pre_last   = (({1'b0, r_pre} + 17'd1) >= i_div);
    assign frame_last = ((CFG_W'(r_frame) + 17'd1) >= i_period);

    // Counter advance
    always_comb begin
        n_pre   = r_pre;
        n_frame = r_frame;
        o_wrap  = 1'b0;
        if (i_restart) begin
            n_pre   = '0;
            n_frame = '0;
        end else if (i_step) begin
            if (!pre_last) begin
                n_pre = r_pre + 1'b1;
            end else begin
                n_pre = '0;
                if (frame_last) begin
                    n_frame = '0;
                    o_wrap  = 1'b1;
                end else begin
                    n_frame = r_frame + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= '0;
            r_frame <= '0;
        end else begin
            r_pre   <= n_pre;
            r_frame <= n_frame;
        end
    end

    assign o_frame_next = PULSE_W'(n_frame);

endmodule

/* dv/servo_pwm_tracker_pkg.sv */
`timescale 1ns / 1ps
// Command tracker for the dual servo PWM generator bench: mirrors the timer,
// the compare lanes and the registers, and checks each result in order.
// Depends on dspwm_pkg for the transaction types, command codes and indexes.
package servo_pwm_tracker_pkg;
    import dspwm_pkg::*;

    // frame length limit: 2^COUNT_WIDTH, never above 65536
    localparam int unsigned FRAME_MAX = (COUNT_WIDTH_DEF >= 16) ? 65536 :
                                        (1 << COUNT_WIDTH_DEF);

    class servo_pwm_tracker;
        // register copies
        bit               init_done;
        bit [CFG_W-1:0]   div_reg;
        bit [CFG_W-1:0]   period_reg;
        bit [PULSE_W-1:0] min_reg;
        bit [PULSE_W-1:0] max_reg;
        bit [PULSE_W-1:0] center_reg;
        // timer and compare state
        bit               running;
        int unsigned      presc_cnt;
        int unsigned      frame_cnt;
        bit [PULSE_W-1:0] pan_act;
        bit [PULSE_W-1:0] tilt_act;
        bit [PULSE_W-1:0] pan_pre;
        bit [PULSE_W-1:0] tilt_pre;
        // pin levels still owed by the block, oldest first
        t_out_item        pending_pins[$];
        int               mismatches;
        int               compared;
        int               commands;
        int               wraps;

        function new();
            reset_state();
        endfunction

        function void reset_state();
            init_done  = 1'b1;
            div_reg    = DIV_RST;
            period_reg = CFG_W'(PERIOD_RST);
            min_reg    = MIN_RST;
            max_reg    = MAX_RST;
            center_reg = CENTER_RST;
            running    = 1'b0;
            presc_cnt  = 0;
            frame_cnt  = 0;
            load_all(CENTER_RST, CENTER_RST);
        endfunction

        function void load_all(bit [PULSE_W-1:0] pan, bit [PULSE_W-1:0] tilt);
            pan_act  = pan;
            pan_pre  = pan;
            tilt_act = tilt;
            tilt_pre = tilt;
        endfunction

        function bit in_window(bit [PULSE_W-1:0] p);
            return (p >= min_reg) && (p <= max_reg);
        endfunction

        // divider 0 behaves as 1, anything above 65536 as 65536
        function int unsigned eff_div();
            if (div_reg == 0) return 1;
            if (div_reg > DIV_MAX) return DIV_MAX;
            return div_reg;
        endfunction

        function int unsigned eff_period();
            if (period_reg < 2) return 2;
            if (period_reg > FRAME_MAX) return FRAME_MAX;
            return period_reg;
        endfunction

        // one input clock tick; preloads move to the active compares on wrap
        function void advance();
            if (!running) return;
            if (presc_cnt + 1 < eff_div()) begin
                presc_cnt++;
                return;
            end
            presc_cnt = 0;
            if (frame_cnt + 1 < eff_period()) begin
                frame_cnt++;
            end else begin
                frame_cnt = 0;
                pan_act   = pan_pre;
                tilt_act  = tilt_pre;
                wraps++;
            end
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
            case (idx)
                CFG_INIT_DONE:    init_done  = data[0];
                CFG_PRESCALE_DIV: div_reg    = data;
                CFG_PERIOD_TICKS: period_reg = data;
                CFG_MIN_PULSE:    min_reg    = data[PULSE_W-1:0];
                CFG_MAX_PULSE:    max_reg    = data[PULSE_W-1:0];
                CFG_CENTER_PULSE: begin
                    center_reg = data[PULSE_W-1:0];
                    // centre only reaches the compares while stopped
                    if (!running) load_all(center_reg, center_reg);
                end
                default: ;
            endcase
        endfunction

        function t_out_item step_command(t_in_item c);
            t_out_item r;
            bit        acc;
            bit        can_set;
            acc     = 1'b0;
            can_set = init_done && running;
            case (c.op)
                OP_TICK: begin
                    advance();
                    acc = 1'b1;
                end
                OP_ENABLE: begin
                    if (init_done && in_window(c.pan_pulse) && in_window(c.tilt_pulse)) begin
                        load_all(c.pan_pulse, c.tilt_pulse);
                        presc_cnt = 0;
                        frame_cnt = 0;
                        running   = 1'b1;
                        acc       = 1'b1;
                    end else begin
                        // a rejected enable stops the block
                        running = 1'b0;
                    end
                end
                OP_SET_BOTH: begin
                    if (can_set && in_window(c.pan_pulse) && in_window(c.tilt_pulse)) begin
                        pan_pre  = c.pan_pulse;
                        tilt_pre = c.tilt_pulse;
                        acc      = 1'b1;
                    end
                end
                OP_SET_PAN: begin
                    if (can_set && in_window(c.pan_pulse)) begin
                        pan_pre = c.pan_pulse;
                        acc     = 1'b1;
                    end
                end
                OP_SET_TILT: begin
                    if (can_set && in_window(c.tilt_pulse)) begin
                        tilt_pre = c.tilt_pulse;
                        acc      = 1'b1;
                    end
                end
                OP_DISABLE: begin
                    running = 1'b0;
                    acc     = 1'b1;
                end
                default: ;
            endcase
            r.pan_out  = running && (frame_cnt < pan_act);
            r.tilt_out = running && (frame_cnt < tilt_act);
            r.accepted = acc;
            r.running  = running;
            return r;
        endfunction

        function void note_command(t_in_item c);
            commands++;
            pending_pins.push_back(step_command(c));
        endfunction

        function void report(string field, logic want, logic got);
            mismatches++;
            $display("%0t: %s mismatch, expected %b got %b", $time, field, want, got);
        endfunction

        function void check_pins(t_out_item got);
            t_out_item want;
            compared++;
            if (pending_pins.size() == 0) begin
                mismatches++;
                $display("%0t: result %b with no command outstanding, expected none",
                         $time, got);
                return;
            end
            want = pending_pins.pop_front();
            if (got.pan_out !== want.pan_out)   report("pan_out", want.pan_out, got.pan_out);
            if (got.tilt_out !== want.tilt_out) report("tilt_out", want.tilt_out, got.tilt_out);
            if (got.accepted !== want.accepted) report("accepted", want.accepted, got.accepted);
            if (got.running !== want.running)   report("running", want.running, got.running);
        endfunction

        function int pending();
            return pending_pins.size();
        endfunction
    endclass

endpackage

/* dv/dual_servo_pwm_generator_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for dual_servo_pwm_generator_core: directed and random
// commands under several register settings. Depends on dspwm_pkg and
// servo_pwm_tracker_pkg.
module dual_servo_pwm_generator_core_tb;
    import dspwm_pkg::*;
    import servo_pwm_tracker_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 203;
    localparam int SETTLE       = 3;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        bit               init;
        logic [CFG_W-1:0] div;
        logic [CFG_W-1:0] per;
        logic [PULSE_W-1:0] lo;
        logic [PULSE_W-1:0] hi;
        logic [PULSE_W-1:0] ctr;
    } t_setting;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    servo_pwm_tracker trk = new();

    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    dual_servo_pwm_generator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // note accepted commands and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) trk.note_command(i_in_data);
            if (o_out_valid && !i_out_stall) trk.check_pins(o_out_data);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_gaps && ($urandom_range(0, 99) < 6);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in_item cmd(logic [OP_W-1:0] op, logic [PULSE_W-1:0] pan,
                                     logic [PULSE_W-1:0] tilt);
        t_in_item c;
        c.op         = op;
        c.pan_pulse  = pan;
        c.tilt_pulse = tilt;
        return c;
    endfunction

    // mostly in-window widths, some at or just past the window edges, some noise
    function automatic logic [PULSE_W-1:0] pick_pulse();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && trk.min_reg <= trk.max_reg)
            return PULSE_W'($urandom_range(trk.min_reg, trk.max_reg));
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       return trk.min_reg;
                1:       return trk.max_reg;
                2:       return trk.min_reg - 1'b1;
                default: return trk.max_reg + 1'b1;
            endcase
        end
        return PULSE_W'($urandom);
    endfunction

    function automatic t_in_item make_command();
        t_in_item c;
        int       r;
        c.pan_pulse  = pick_pulse();
        c.tilt_pulse = pick_pulse();
        r = $urandom_range(0, 99);
        // favour enable while stopped so the timer spends most time running
        if (!trk.running && r < 40) c.op = OP_ENABLE;
        else if (r < 70)            c.op = OP_TICK;
        else if (r < 75)            c.op = OP_ENABLE;
        else if (r < 82)            c.op = OP_SET_BOTH;
        else if (r < 87)            c.op = OP_SET_PAN;
        else if (r < 92)            c.op = OP_SET_TILT;
        else if (r < 96)            c.op = OP_DISABLE;
        else c.op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
        return c;
    endfunction

    task automatic send_item(input t_in_item c);
        while (tx_gaps && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        // let the last accepted command reach the tracker queue first
        @(posedge i_clk);
        while (trk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        trk.write_reg(idx, val);
    endtask

    task automatic set_config(input t_setting s);
        write_reg(CFG_INIT_DONE, CFG_W'(s.init));
        write_reg(CFG_PRESCALE_DIV, s.div);
        write_reg(CFG_PERIOD_TICKS, s.per);
        write_reg(CFG_MIN_PULSE, CFG_W'(s.lo));
        write_reg(CFG_MAX_PULSE, CFG_W'(s.hi));
        write_reg(CFG_CENTER_PULSE, CFG_W'(s.ctr));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_setting plan [PHASES];
        t_setting quick;
        plan = '{
            '{1'b1, 17'd1,       17'd8,     16'd0,     16'd10,    16'd3},
            '{1'b1, 17'd3,       17'd5,     16'd1,     16'd7,     16'd7},
            '{1'b1, 17'd0,       17'd0,     16'd0,     16'd3,     16'd0},
            '{1'b1, 17'd2,       17'd1,     16'd2,     16'd2,     16'd2},
            '{1'b0, 17'd1,       17'd6,     16'd0,     16'd8,     16'd4},
            '{1'b1, 17'h1FFFF,   17'd65536, 16'd0,     16'd65535, 16'd65535},
            '{1'b1, 17'd1,       17'd3,     16'd5,     16'd3,     16'd1},
            '{1'b1, 17'd2,       17'd12,    16'd0,     16'd15,    16'd6},
            '{1'b1, 17'd1,       17'd2,     16'd65535, 16'd65535, 16'd0}
        };
        quick = '{1'b1, 17'd1, 17'd4, 16'd0, 16'd65535, 16'd2};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stopped tick, window edges, rejections, unused codes
        send_item(cmd(OP_TICK, 16'd0, 16'd0));
        send_item(cmd(OP_SET_BOTH, 16'd1500, 16'd1500));
        send_item(cmd(OP_ENABLE, 16'd500, 16'd2500));
        send_item(cmd(OP_TICK, 16'd0, 16'd0));
        send_item(cmd(OP_SET_BOTH, 16'd499, 16'd2500));
        send_item(cmd(OP_SET_PAN, 16'd2501, 16'd0));
        send_item(cmd(OP_SET_TILT, 16'd0, 16'd500));
        send_item(cmd(OP_SET_BOTH, 16'hFFFF, 16'h0000));
        send_item(cmd(OP_UNUSED_A, 16'hFFFF, 16'hFFFF));
        send_item(cmd(OP_UNUSED_B, 16'h0000, 16'h0000));
        send_item(cmd(OP_ENABLE, 16'h0000, 16'hFFFF));
        send_item(cmd(OP_DISABLE, 16'h5555, 16'hAAAA));
        wait_drain();

        // short frame: zero compare, compare past the period, wrap with preload
        set_config(quick);
        send_item(cmd(OP_ENABLE, 16'h0000, 16'hFFFF));
        repeat (4) send_item(cmd(OP_TICK, 16'd0, 16'd0));
        send_item(cmd(OP_SET_PAN, 16'd3, 16'd0));
        repeat (3) send_item(cmd(OP_TICK, 16'd0, 16'd0));
        wait_drain();

        // setup cleared while running: timer keeps going, commands refused
        write_reg(CFG_INIT_DONE, '0);
        i_cfg_we <= 1'b0;
        send_item(cmd(OP_TICK, 16'd0, 16'd0));
        send_item(cmd(OP_SET_BOTH, 16'd1, 16'd1));
        send_item(cmd(OP_ENABLE, 16'd1, 16'd1));
        wait_drain();

        // random commands under each setting
        for (int p = 0; p < PHASES; p++) begin
            set_config(plan[p]);
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 7 && n == 40) hold_requests++;
                if (p == 1 && n == 100) wait_drain();
                send_item(make_command());
            end
            wait_drain();
        end

        $display("Covered %0d commands over %0d register settings: %0d results compared,",
                 trk.commands, PHASES + 2, trk.compared);
        $display("%0d frame wraps, one long output hold-off and one full drain pause.",
                 trk.wraps);
        if (trk.mismatches == 0 && trk.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/dspwm_pkg.sv
hw/rtl/dspwm_lane.sv
hw/rtl/dspwm_timer.sv
hw/rtl/dual_servo_pwm_generator_core.sv
dv/servo_pwm_tracker_pkg.sv
dv/dual_servo_pwm_generator_core_tb.sv
